/* hdl/uule_pkg.sv */
// Shared types, constants and character mapping for the uuencode line encoder.
`timescale 1ns / 1ps

package uule_pkg;

   localparam int MAX_LINE_BYTES_DEFAULT = 45;
   localparam int QUEUE_DEPTH_DEFAULT    = 4;

   localparam logic [6:0] CHAR_OFFSET = 7'h20;
   localparam logic [6:0] CHAR_ZERO   = 7'h60;

   // Position of a character within the results of one command.
   typedef enum logic [2:0] {
      STEP_HDR,
      STEP_S0,
      STEP_S1,
      STEP_S2,
      STEP_S3
   } uule_step_type;

   // One classified input byte, as handed from the front to the back.
   typedef struct packed {
      logic        reject;
      logic        has_header;
      logic [5:0]  length;
      logic        has_group;
      logic [23:0] group;
      logic        eol;
   } uule_cmd_type;

   function automatic logic [6:0] map_six(input logic [5:0] v);
      logic [6:0] ch;
      if (v == 6'd0) begin
         ch = CHAR_ZERO;
      end else begin
         ch = {1'b0, v} + CHAR_OFFSET;
      end
      return ch;
   endfunction

endpackage

/* hdl/uule_front.sv */
// Front end: tracks the open line and classifies each input byte into a command.
`timescale 1ns / 1ps

module uule_front #(
   parameter int MAX_LINE_BYTES = uule_pkg::MAX_LINE_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic [5:0]            line_length,
   output logic                  cmd_push,
   output uule_pkg::uule_cmd_type cmd
);
   import uule_pkg::*;

   localparam logic [5:0] MAX_LEN = 6'(MAX_LINE_BYTES);

   logic [15:0] pending_ff, pending_in;
   logic [1:0]  fill_ff, fill_in;
   logic [5:0]  left_ff, left_in;
   logic        open_ff, open_in;

   logic        start;
   logic        bad_len;
   logic [5:0]  left_cur;
   logic [1:0]  fill_cur;
   logic [15:0] pend_cur;
   logic [1:0]  fill_new;
   logic [23:0] acc;
   logic        flush;

   always_comb begin
      start    = !open_ff || (left_ff == 6'd0);
      bad_len  = (line_length == 6'd0) || (line_length > MAX_LEN);
      left_cur = start ? line_length : left_ff;
      fill_cur = start ? 2'd0 : fill_ff;
      pend_cur = start ? 16'd0 : pending_ff;
      fill_new = (fill_cur == 2'd3) ? 2'd3 : fill_cur + 2'd1;
      acc      = {pend_cur, data_byte};
      left_in  = left_cur - 6'd1;
      flush    = (fill_new == 2'd3) || (left_in == 6'd0);

      cmd            = '0;
      cmd.reject     = start && bad_len;
      cmd.has_header = start && !bad_len;
      cmd.length     = line_length;
      cmd.has_group  = !(start && bad_len) && flush;
      cmd.eol        = (left_in == 6'd0);
      // A short final group is left-aligned and padded with zero bytes.
      case (fill_new)
         2'd1:    cmd.group = {acc[7:0], 16'd0};
         2'd2:    cmd.group = {acc[15:0], 8'd0};
         default: cmd.group = acc;
      endcase
      cmd_push = accept && (start || flush);

      open_in    = left_in != 6'd0;
      pending_in = flush ? 16'd0 : acc[15:0];
      fill_in    = flush ? 2'd0 : fill_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         fill_ff    <= '0;
         left_ff    <= '0;
         open_ff    <= 1'b0;
      end else if (accept) begin
         if (start && bad_len) begin
            open_ff <= 1'b0;
         end else begin
            pending_ff <= pending_in;
            fill_ff    <= fill_in;
            left_ff    <= left_in;
            open_ff    <= open_in;
         end
      end
   end

endmodule

/* hdl/uule_queue.sv */
// Small command queue between the front and the back.
`timescale 1ns / 1ps

module uule_queue #(
   parameter int DEPTH = uule_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  uule_pkg::uule_cmd_type push_cmd,
   output logic                   full,
   output logic                   empty,
   input  logic                   pop,
   output uule_pkg::uule_cmd_type head_cmd
);
   import uule_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   uule_cmd_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full     = count_ff == CNT_W'(DEPTH);
      empty    = count_ff == '0;
      head_cmd = slot_ff[rd_ff];
      wr_in    = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      rd_in    = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_in;
         end
         if (pop) begin
            rd_ff <= rd_in;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("command popped from an empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

/* hdl/uule_back.sv */
// Back end: walks each command one character per cycle into the output register, while the response is not stalled.
`timescale 1ns / 1ps

module uule_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  uule_pkg::uule_cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   out_valid,
   input  logic                   out_take,
   output logic [6:0]             out_char,
   output logic                   last_of_run,
   output logic                   end_of_line,
   output logic                   rejected
);
   import uule_pkg::*;

   uule_step_type step_ff, step_in;
   logic          active_ff, active_in;
   logic          valid_ff, valid_in;
   logic [6:0]    char_ff, char_in;
   logic          last_ff, last_in;
   logic          eol_ff, eol_in;
   logic          rej_ff, rej_in;

   uule_step_type cur_step;
   uule_step_type last_step;
   logic          emit;
   logic          is_last;

   always_comb begin
      cur_step  = active_ff ? step_ff : (cmd.has_header ? STEP_HDR : STEP_S0);
      last_step = cmd.has_group ? STEP_S3 : STEP_HDR;
      emit      = !cmd_empty && (!valid_ff || out_take);
      is_last   = cmd.reject || (cur_step == last_step);
      cmd_pop   = emit && is_last;

      case (cur_step)
         STEP_HDR: char_in = {1'b0, cmd.length} + CHAR_OFFSET;
         STEP_S0:  char_in = map_six(cmd.group[23:18]);
         STEP_S1:  char_in = map_six(cmd.group[17:12]);
         STEP_S2:  char_in = map_six(cmd.group[11:6]);
         STEP_S3:  char_in = map_six(cmd.group[5:0]);
         default:  char_in = CHAR_ZERO;
      endcase
      if (cmd.reject) begin
         char_in = '0;
      end
      last_in = is_last;
      eol_in  = !cmd.reject && cmd.eol && (cur_step == STEP_S3);
      rej_in  = cmd.reject;

      case (cur_step)
         STEP_HDR: step_in = STEP_S0;
         STEP_S0:  step_in = STEP_S1;
         STEP_S1:  step_in = STEP_S2;
         STEP_S2:  step_in = STEP_S3;
         default:  step_in = STEP_HDR;
      endcase
      active_in = emit ? !is_last : active_ff;

      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         active_ff <= 1'b0;
         step_ff   <= STEP_HDR;
      end else begin
         valid_ff  <= valid_in;
         active_ff <= active_in;
         if (emit) begin
            step_ff <= step_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         char_ff <= char_in;
         last_ff <= last_in;
         eol_ff  <= eol_in;
         rej_ff  <= rej_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_char    = char_ff;
   assign last_of_run = last_ff;
   assign end_of_line = eol_ff;
   assign rejected    = rej_ff;

   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rej_ff |-> last_ff && !eol_ff)
      else $error("rejection word is not a single final word");
   a_eol_closes: assert property (@(posedge clock) disable iff (reset)
      valid_ff && eol_ff |-> last_ff)
      else $error("end of line not on the last word of its byte");
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !active_ff)
      else $error("sequencer still active after its command left");

endmodule

/* hdl/uu_line_encoder.sv */
// Top level of the uuencode line encoder: front, command queue and back.
//
//  channel   ports                                        word
//  request   req_push / req_full                          data_byte, line_length
//  response  rsp_empty / rsp_pop                          out_char and flags
//
// Each byte yields zero to five words: none while its group is still filling, a header on
// a line's first byte, four words when a group completes, and a single rejection word for
// a bad line length. The back end issues one word per cycle while the response is not stalled.
// The front accepts a byte every cycle while the command queue has room.
// Reset clears line state, the queue and the output valid flag.
// A stalled response holds the back end; the queue absorbs bytes until full.
`timescale 1ns / 1ps

module uu_line_encoder #(
   parameter int MAX_LINE_BYTES = uule_pkg::MAX_LINE_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH    = uule_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic [5:0] req_line_length,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_end_of_line,
   output logic       rsp_rejected
);
   import uule_pkg::*;

   logic         accept;
   logic         cmd_push;
   uule_cmd_type push_cmd;
   uule_cmd_type head_cmd;
   logic         q_empty;
   logic         q_pop;
   logic         out_valid;

   assign accept    = req_push && !req_full;
   assign rsp_empty = !out_valid;

   uule_front #(
      .MAX_LINE_BYTES(MAX_LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .line_length(req_line_length),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   uule_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(push_cmd),
      .full    (req_full),
      .empty   (q_empty),
      .pop     (q_pop),
      .head_cmd(head_cmd)
   );

   uule_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (q_empty),
      .cmd        (head_cmd),
      .cmd_pop    (q_pop),
      .out_valid  (out_valid),
      .out_take   (rsp_pop),
      .out_char   (rsp_out_char),
      .last_of_run(rsp_last_of_run),
      .end_of_line(rsp_end_of_line),
      .rejected   (rsp_rejected)
   );

endmodule
